[src/sdo_pkg.sv]
// ----------------------------------------------------------------------------
// SDO expedited client package
// Shared constants, codes and controller/datapath handshake types.
// ----------------------------------------------------------------------------
package sdo_pkg;

  // Storage sizes.
  localparam int unsigned QUEUE_DEPTH = 256;
  localparam int unsigned SUB_COUNT   = 256;
  localparam int unsigned QA_W        = $clog2(QUEUE_DEPTH);
  localparam int unsigned QC_W        = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned SUB_W       = $clog2(SUB_COUNT);

  // Configuration port.
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] CFG_NODE_ID      = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BUS_OPEN     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_OBJECT_INDEX = 2'd2;

  // Configuration reset values.
  localparam logic [6:0]  NODE_ID_RST      = 7'd1;
  localparam logic [15:0] OBJECT_INDEX_RST = 16'h23E0;

  // Request types.
  localparam logic [2:0] REQ_FRAME    = 3'd0;
  localparam logic [2:0] REQ_READ     = 3'd1;
  localparam logic [2:0] REQ_WRITE    = 3'd2;
  localparam logic [2:0] REQ_DEFINE   = 3'd3;
  localparam logic [2:0] REQ_READ_ALL = 3'd4;

  // Status codes.
  localparam logic [2:0] ST_NONE      = 3'd0;
  localparam logic [2:0] ST_ABORT     = 3'd1;
  localparam logic [2:0] ST_SEGMENTED = 3'd2;
  localparam logic [2:0] ST_READ_DONE = 3'd3;
  localparam logic [2:0] ST_WRITE_ACK = 3'd4;
  localparam logic [2:0] ST_READ_ONLY = 3'd5;
  localparam logic [2:0] ST_QUEUE_FULL = 3'd6;

  // Pending transfer kinds.
  localparam logic [1:0] PEND_NONE  = 2'd0;
  localparam logic [1:0] PEND_READ  = 2'd1;
  localparam logic [1:0] PEND_WRITE = 2'd2;

  // Identifier bases and SDO command bytes.
  localparam logic [10:0] COB_TX_BASE = 11'h600;
  localparam logic [10:0] COB_RX_BASE = 11'h580;
  localparam logic [7:0]  CMD_ABORT   = 8'h80;
  localparam logic [7:0]  CMD_UPLOAD  = 8'h40;
  localparam logic [7:0]  CMD_DL_ACK  = 8'h60;
  localparam logic [7:0]  CMD_CS_MASK = 8'hE0;
  localparam logic [7:0]  CMD_READ    = 8'h40;
  localparam logic [7:0]  CMD_WR1     = 8'h2F;
  localparam logic [7:0]  CMD_WR2     = 8'h2B;
  localparam logic [7:0]  CMD_WR3     = 8'h27;
  localparam logic [7:0]  CMD_WR4     = 8'h23;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;
    logic exec;
    logic walk;
    logic pop;
    logic check;
    logic load;
  } sdo_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic req_is_all;
    logic walk_done;
    logic disp_go;
    logic out_free;
  } sdo_stat_t;

  // Controller states.
  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_EXEC = 6'b000010,
    S_WALK = 6'b000100,
    S_DISP = 6'b001000,
    S_DCHK = 6'b010000,
    S_DONE = 6'b100000
  } sdo_state_e;

endpackage

[src/sdo_if.sv]
// ----------------------------------------------------------------------------
// SDO client stream interfaces
// Valid/ready channels for incoming items and outgoing results.
// ----------------------------------------------------------------------------
interface sdo_req_if;
  logic        valid;
  logic        ready;
  logic [2:0]  req_type;
  logic [10:0] can_id;
  logic [7:0]  rx_cmd;
  logic [15:0] rx_index;
  logic [7:0]  sub_index;
  logic [31:0] rx_data;
  logic [31:0] write_value;
  logic [2:0]  write_size;
  logic        entry_writable;

  modport source (
    output valid, req_type, can_id, rx_cmd, rx_index, sub_index, rx_data,
           write_value, write_size, entry_writable,
    input  ready
  );
  modport sink (
    input  valid, req_type, can_id, rx_cmd, rx_index, sub_index, rx_data,
           write_value, write_size, entry_writable,
    output ready
  );
endinterface

interface sdo_rsp_if;
  logic        valid;
  logic        ready;
  logic        tx_valid;
  logic [10:0] tx_cob_id;
  logic [7:0]  tx_cmd;
  logic [7:0]  tx_sub;
  logic [31:0] tx_value;
  logic [2:0]  status;
  logic [7:0]  status_sub;
  logic [31:0] read_value;
  logic [2:0]  read_size;

  modport source (
    output valid, tx_valid, tx_cob_id, tx_cmd, tx_sub, tx_value, status,
           status_sub, read_value, read_size,
    input  ready
  );
  modport sink (
    input  valid, tx_valid, tx_cob_id, tx_cmd, tx_sub, tx_value, status,
           status_sub, read_value, read_size,
    output ready
  );
endinterface

[src/sdo_ctrl.sv]
// ----------------------------------------------------------------------------
// SDO client controller
// Sequences capture, execution, table walk, queue dispatch and result load.
// ----------------------------------------------------------------------------
module sdo_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  sdo_pkg::sdo_stat_t stat_i,
  output sdo_pkg::sdo_cmd_t  cmd_o
);
  import sdo_pkg::*;

  sdo_state_e state_q, state_d;

  // Next state and command decode.
  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd_o.exec = 1'b1;
        state_d    = stat_i.req_is_all ? S_WALK : S_DISP;
      end
      S_WALK: begin
        cmd_o.walk = 1'b1;
        if (stat_i.walk_done) begin
          state_d = S_DISP;
        end
      end
      S_DISP: begin
        if (stat_i.disp_go) begin
          cmd_o.pop = 1'b1;
          state_d   = S_DCHK;
        end else begin
          state_d = S_DONE;
        end
      end
      S_DCHK: begin
        cmd_o.check = 1'b1;
        state_d     = S_DONE;
      end
      S_DONE: begin
        if (stat_i.out_free) begin
          cmd_o.load = 1'b1;
          state_d    = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // State register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

[src/sdo_dp.sv]
// ----------------------------------------------------------------------------
// SDO client datapath
// Configuration, subindex tables, read queue, pending transfer and results.
// ----------------------------------------------------------------------------
module sdo_dp (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [sdo_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [sdo_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  input  sdo_pkg::sdo_cmd_t              cmd_i,
  output sdo_pkg::sdo_stat_t             stat_o,
  sdo_req_if.sink                        req_i,
  sdo_rsp_if.source                      rsp_o
);
  import sdo_pkg::*;

  localparam int unsigned QS_W = QC_W + 1;

  // Byte count to value mask.
  function automatic logic [31:0] size_mask(input logic [2:0] bytes);
    logic [31:0] m;
    case (bytes)
      3'd1:    m = 32'h0000_00FF;
      3'd2:    m = 32'h0000_FFFF;
      3'd3:    m = 32'h00FF_FFFF;
      default: m = 32'hFFFF_FFFF;
    endcase
    return m;
  endfunction

  // Subindex range check against the table size.
  function automatic logic sub_in_range(input logic [7:0] sub);
    return ({1'b0, sub} < 9'(SUB_COUNT));
  endfunction

  // Configuration registers.
  logic [6:0]  node_id_q;
  logic        bus_open_q, bus_open_d;
  logic [15:0] object_index_q;

  // Tables, one flop per subindex.
  logic [SUB_COUNT-1:0] known_q, known_d;
  logic [SUB_COUNT-1:0] writable_q, writable_d;

  // Queue control and memory.
  logic [QA_W-1:0]  head_q, head_d;
  logic [QC_W-1:0]  count_q, count_d;
  logic [7:0]       q_mem [QUEUE_DEPTH];
  logic [7:0]       rd_q;
  logic             push_en;
  logic [7:0]       push_sub;
  logic [QA_W-1:0]  waddr;
  logic [QS_W-1:0]  wsum;
  logic             full;

  logic [1:0]       pending_q, pending_d;
  logic [SUB_W-1:0] walk_idx_q, walk_idx_d;

  // Captured item.
  logic [2:0]  it_req_q;
  logic [10:0] it_can_id_q;
  logic [7:0]  it_cmd_q;
  logic [15:0] it_index_q;
  logic [7:0]  it_sub_q;
  logic [31:0] it_rx_data_q;
  logic [31:0] it_wval_q;
  logic [2:0]  it_wsize_q;
  logic        it_wable_q;

  // Result under construction.
  logic        res_txv_q, res_txv_d;
  logic [10:0] res_txid_q, res_txid_d;
  logic [7:0]  res_txcmd_q, res_txcmd_d;
  logic [7:0]  res_txsub_q, res_txsub_d;
  logic [31:0] res_txval_q, res_txval_d;
  logic [2:0]  res_st_q, res_st_d;
  logic [7:0]  res_stsub_q, res_stsub_d;
  logic [31:0] res_rval_q, res_rval_d;
  logic [2:0]  res_rsize_q, res_rsize_d;

  // Output register.
  logic        out_valid_q;
  logic        out_txv_q;
  logic [10:0] out_txid_q;
  logic [7:0]  out_txcmd_q;
  logic [7:0]  out_txsub_q;
  logic [31:0] out_txval_q;
  logic [2:0]  out_st_q;
  logic [7:0]  out_stsub_q;
  logic [31:0] out_rval_q;
  logic [2:0]  out_rsize_q;

  // Derived identifiers and lookups.
  logic [6:0]  node_num;
  logic [10:0] rx_id;
  logic [10:0] tx_id;
  logic        item_known;
  logic        item_writable;
  logic        qs_known;
  logic        walk_known;
  logic        frame_match;
  logic [2:0]  wbytes;
  logic [7:0]  wcmd;

  assign node_num      = (node_id_q == 7'd0) ? 7'd1 : node_id_q;
  assign rx_id         = COB_RX_BASE + 11'(node_num);
  assign tx_id         = COB_TX_BASE + 11'(node_num);
  assign item_known    = sub_in_range(it_sub_q) && known_q[it_sub_q[SUB_W-1:0]];
  assign item_writable = writable_q[it_sub_q[SUB_W-1:0]];
  assign qs_known      = sub_in_range(rd_q) && known_q[rd_q[SUB_W-1:0]];
  assign walk_known    = known_q[walk_idx_q];
  assign frame_match   = (it_can_id_q == rx_id) && (it_index_q == object_index_q) &&
                         item_known;
  assign full          = (count_q == QC_W'(QUEUE_DEPTH));

  // Tail address: head plus count, wrapped once.
  assign wsum  = QS_W'(head_q) + QS_W'(count_q);
  assign waddr = (wsum >= QS_W'(QUEUE_DEPTH)) ? QA_W'(wsum - QS_W'(QUEUE_DEPTH))
                                              : QA_W'(wsum);

  // Write size and command byte.
  always_comb begin
    wbytes = ((it_wsize_q >= 3'd1) && (it_wsize_q <= 3'd3)) ? it_wsize_q : 3'd4;
    case (wbytes)
      3'd1:    wcmd = CMD_WR1;
      3'd2:    wcmd = CMD_WR2;
      3'd3:    wcmd = CMD_WR3;
      default: wcmd = CMD_WR4;
    endcase
  end

  // Status toward the controller.
  assign stat_o.req_is_all = (it_req_q == REQ_READ_ALL);
  assign stat_o.walk_done  = (walk_idx_q == SUB_W'(SUB_COUNT - 1)) || (walk_known && full);
  assign stat_o.disp_go    = !res_txv_q && (pending_q == PEND_NONE) && bus_open_q &&
                             (count_q != '0);
  assign stat_o.out_free   = !out_valid_q || rsp_o.ready;

  // Next-state logic for tables, queue, pending transfer and result.
  always_comb begin
    known_d     = known_q;
    writable_d  = writable_q;
    head_d      = head_q;
    count_d     = count_q;
    pending_d   = pending_q;
    walk_idx_d  = walk_idx_q;
    bus_open_d  = bus_open_q;
    push_en     = 1'b0;
    push_sub    = '0;
    res_txv_d   = res_txv_q;
    res_txid_d  = res_txid_q;
    res_txcmd_d = res_txcmd_q;
    res_txsub_d = res_txsub_q;
    res_txval_d = res_txval_q;
    res_st_d    = res_st_q;
    res_stsub_d = res_stsub_q;
    res_rval_d  = res_rval_q;
    res_rsize_d = res_rsize_q;

    // A new item starts from an empty result.
    if (cmd_i.capture) begin
      res_txv_d   = 1'b0;
      res_txid_d  = '0;
      res_txcmd_d = '0;
      res_txsub_d = '0;
      res_txval_d = '0;
      res_st_d    = ST_NONE;
      res_stsub_d = '0;
      res_rval_d  = '0;
      res_rsize_d = '0;
    end

    // Item execution.
    if (cmd_i.exec) begin
      unique case (it_req_q)
        REQ_FRAME: begin
          if (frame_match) begin
            if (it_cmd_q == CMD_ABORT) begin
              res_st_d    = ST_ABORT;
              res_stsub_d = it_sub_q;
              res_rval_d  = it_rx_data_q;
              pending_d   = PEND_NONE;
            end else if ((it_cmd_q & CMD_CS_MASK) == CMD_UPLOAD) begin
              pending_d   = PEND_NONE;
              res_stsub_d = it_sub_q;
              if (it_cmd_q[1:0] != 2'b11) begin
                res_st_d = ST_SEGMENTED;
              end else begin
                res_rsize_d = 3'd4 - {1'b0, it_cmd_q[3:2]};
                res_rval_d  = it_rx_data_q & size_mask(3'd4 - {1'b0, it_cmd_q[3:2]});
                res_st_d    = ST_READ_DONE;
              end
            end else if (it_cmd_q == CMD_DL_ACK) begin
              pending_d   = PEND_NONE;
              res_stsub_d = it_sub_q;
              if (full) begin
                res_st_d = ST_QUEUE_FULL;
              end else begin
                res_st_d = ST_WRITE_ACK;
                push_en  = 1'b1;
                push_sub = it_sub_q;
                count_d  = count_q + QC_W'(1);
              end
            end
          end
        end
        REQ_READ: begin
          if (full) begin
            res_st_d    = ST_QUEUE_FULL;
            res_stsub_d = it_sub_q;
          end else begin
            push_en  = 1'b1;
            push_sub = it_sub_q;
            count_d  = count_q + QC_W'(1);
          end
        end
        REQ_WRITE: begin
          if (bus_open_q && item_known && (pending_q == PEND_NONE)) begin
            if (!item_writable) begin
              res_st_d    = ST_READ_ONLY;
              res_stsub_d = it_sub_q;
            end else begin
              res_txv_d   = 1'b1;
              res_txid_d  = tx_id;
              res_txcmd_d = wcmd;
              res_txsub_d = it_sub_q;
              res_txval_d = it_wval_q & size_mask(wbytes);
              pending_d   = PEND_WRITE;
            end
          end
        end
        REQ_DEFINE: begin
          if (sub_in_range(it_sub_q)) begin
            known_d[it_sub_q[SUB_W-1:0]]    = 1'b1;
            writable_d[it_sub_q[SUB_W-1:0]] = it_wable_q;
          end
        end
        REQ_READ_ALL: begin
          head_d     = '0;
          count_d    = '0;
          walk_idx_d = '0;
        end
        default: begin
        end
      endcase
    end

    // Read-all walk: one table entry per cycle.
    if (cmd_i.walk) begin
      walk_idx_d = walk_idx_q + SUB_W'(1);
      if (walk_known) begin
        if (full) begin
          res_st_d    = ST_QUEUE_FULL;
          res_stsub_d = 8'(walk_idx_q);
        end else begin
          push_en  = 1'b1;
          push_sub = 8'(walk_idx_q);
          count_d  = count_q + QC_W'(1);
        end
      end
    end

    // Dispatch: pop the head entry; the memory read lands in rd_q.
    if (cmd_i.pop) begin
      head_d  = (head_q == QA_W'(QUEUE_DEPTH - 1)) ? '0 : head_q + QA_W'(1);
      count_d = count_q - QC_W'(1);
    end

    // Dispatch: send a read if the popped subindex is known.
    if (cmd_i.check && qs_known) begin
      res_txv_d   = 1'b1;
      res_txid_d  = tx_id;
      res_txcmd_d = CMD_READ;
      res_txsub_d = rd_q;
      res_txval_d = '0;
      pending_d   = PEND_READ;
    end

    // Reopening or closing the bus drops the pending transfer and the queue.
    if (cfg_we_i && (cfg_idx_i == CFG_BUS_OPEN)) begin
      bus_open_d = cfg_wdata_i[0];
      pending_d  = PEND_NONE;
      head_d     = '0;
      count_d    = '0;
    end
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      node_id_q      <= NODE_ID_RST;
      bus_open_q     <= 1'b0;
      object_index_q <= OBJECT_INDEX_RST;
      known_q        <= '0;
      writable_q     <= '0;
      head_q         <= '0;
      count_q        <= '0;
      pending_q      <= PEND_NONE;
      walk_idx_q     <= '0;
      out_valid_q    <= 1'b0;
    end else begin
      if (cfg_we_i && (cfg_idx_i == CFG_NODE_ID)) begin
        node_id_q <= cfg_wdata_i[6:0];
      end
      if (cfg_we_i && (cfg_idx_i == CFG_OBJECT_INDEX)) begin
        object_index_q <= cfg_wdata_i[15:0];
      end
      bus_open_q <= bus_open_d;
      known_q    <= known_d;
      writable_q <= writable_d;
      head_q     <= head_d;
      count_q    <= count_d;
      pending_q  <= pending_d;
      walk_idx_q <= walk_idx_d;
      if (cmd_i.load) begin
        out_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers: captured item, result and output.
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      it_req_q     <= req_i.req_type;
      it_can_id_q  <= req_i.can_id;
      it_cmd_q     <= req_i.rx_cmd;
      it_index_q   <= req_i.rx_index;
      it_sub_q     <= req_i.sub_index;
      it_rx_data_q <= req_i.rx_data;
      it_wval_q    <= req_i.write_value;
      it_wsize_q   <= req_i.write_size;
      it_wable_q   <= req_i.entry_writable;
    end
    res_txv_q   <= res_txv_d;
    res_txid_q  <= res_txid_d;
    res_txcmd_q <= res_txcmd_d;
    res_txsub_q <= res_txsub_d;
    res_txval_q <= res_txval_d;
    res_st_q    <= res_st_d;
    res_stsub_q <= res_stsub_d;
    res_rval_q  <= res_rval_d;
    res_rsize_q <= res_rsize_d;
    if (cmd_i.load) begin
      out_txv_q   <= res_txv_q;
      out_txid_q  <= res_txid_q;
      out_txcmd_q <= res_txcmd_q;
      out_txsub_q <= res_txsub_q;
      out_txval_q <= res_txval_q;
      out_st_q    <= res_st_q;
      out_stsub_q <= res_stsub_q;
      out_rval_q  <= res_rval_q;
      out_rsize_q <= res_rsize_q;
    end
  end

  // Read queue memory: one write port, one registered read port.
  always_ff @(posedge clk_i) begin
    if (push_en) begin
      q_mem[waddr] <= push_sub;
    end
    if (cmd_i.pop) begin
      rd_q <= q_mem[head_q];
    end
  end

  // Result channel.
  assign rsp_o.valid      = out_valid_q;
  assign rsp_o.tx_valid   = out_txv_q;
  assign rsp_o.tx_cob_id  = out_txid_q;
  assign rsp_o.tx_cmd     = out_txcmd_q;
  assign rsp_o.tx_sub     = out_txsub_q;
  assign rsp_o.tx_value   = out_txval_q;
  assign rsp_o.status     = out_st_q;
  assign rsp_o.status_sub = out_stsub_q;
  assign rsp_o.read_value = out_rval_q;
  assign rsp_o.read_size  = out_rsize_q;

endmodule

[src/sdo_expedited_client.sv]
// A result is loaded into the output register once its request has passed the
// execute, dispatch and done states, with a dispatch check for a queued read;
// a read-all walks the table entries first. One request is in flight at a time:
// the next is taken after the last result is loaded, later if the output stalls.
// Reset (asynchronous, active low) clears the tables, empties the queue and drops any
// pending transfer at once; the queue memory itself is not cleared.
// ----------------------------------------------------------------------------
// SDO expedited client top level
// Controller and datapath for expedited SDO access to one remote object.
// ----------------------------------------------------------------------------
module sdo_expedited_client (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [sdo_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [sdo_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  sdo_req_if.sink                        req_i,
  sdo_rsp_if.source                      rsp_o
);
  import sdo_pkg::*;

  sdo_cmd_t  cmd;
  sdo_stat_t stat;
  logic      in_ready;

  assign req_i.ready = in_ready;

  // Controller.
  sdo_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (req_i.valid),
    .in_ready_o (in_ready),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  // Datapath.
  sdo_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .req_i       (req_i),
    .rsp_o       (rsp_o)
  );

  // Only one request is in flight: no accept right after an accept.
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_i.valid && in_ready) |=> !in_ready)
    else $error("request accepted while another is in flight");

  // A loaded result is offered on the next cycle.
  a_load_shows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.load |=> rsp_o.valid)
    else $error("loaded result not offered");

  // A queue pop is always followed by the dispatch check.
  a_pop_check: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.pop |=> cmd.check)
    else $error("queue pop without dispatch check");

  // The controller issues at most one command per cycle.
  a_one_cmd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(cmd))
    else $error("more than one datapath command");

endmodule

[sim/tb_top.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// SDO expedited client testbench
// Drives requests through the valid/ready request channel, predicts every
// reply with a cycle-free copy of the client's table, read queue and pending
// transfer, and compares each reply field by field. A short table of directed
// requests is followed by random requests under several register settings
// and idle patterns on both channels.
// ----------------------------------------------------------------------------
module tb_top;
  import sdo_pkg::*;

  // Request type that the block leaves unused.
  localparam logic [2:0] REQ_SPARE = 3'd7;

  localparam int unsigned LIMIT_CYCLES = 3000000;
  localparam int          HOLD_CYCLES  = 200;
  localparam int          MAX_PRINTS   = 200;

  typedef struct packed {
    logic [2:0]  req_type;
    logic [10:0] can_id;
    logic [7:0]  rx_cmd;
    logic [15:0] rx_index;
    logic [7:0]  sub_index;
    logic [31:0] rx_data;
    logic [31:0] write_value;
    logic [2:0]  write_size;
    logic        entry_writable;
  } sdo_req_t;

  typedef struct packed {
    logic        tx_valid;
    logic [10:0] tx_cob_id;
    logic [7:0]  tx_cmd;
    logic [7:0]  tx_sub;
    logic [31:0] tx_value;
    logic [2:0]  status;
    logic [7:0]  status_sub;
    logic [31:0] read_value;
    logic [2:0]  read_size;
  } reply_t;

  // One line of the directed table; typed rows carry their own reply.
  typedef struct packed {
    logic     typed;
    reply_t   rp;
    sdo_req_t rq;
  } row_t;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_wdata_i;

  sdo_req_if req_if ();
  sdo_rsp_if rsp_if ();

  sdo_expedited_client dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .req_i       (req_if),
    .rsp_o       (rsp_if)
  );

  // Shadow copy of the client's registers and state.
  logic [6:0]  cfg_node;
  logic        cfg_bus;
  logic [15:0] cfg_obj;
  bit          sub_known    [SUB_COUNT];
  bit          sub_writable [SUB_COUNT];
  logic [7:0]  rd_fifo      [QUEUE_DEPTH];
  int unsigned rd_head;
  int unsigned rd_count;
  logic [1:0]  xfer_kind;
  logic [7:0]  xfer_sub;

  reply_t      replies_due [$];
  row_t        rows [$];
  int          err_cnt;
  int          reply_cnt;
  int unsigned cycle_cnt;
  int          req_idle_pct;
  int          rsp_idle_pct;
  bit          hold_start;
  int          hold_left;

  // Clock: 8 ns period.
  initial clk_i = 1'b0;
  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Run limit.
  initial cycle_cnt = 0;
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= LIMIT_CYCLES) begin
      $display("status: fail");
      $finish;
    end
  end

  function automatic logic [6:0] eff_node();
    return (cfg_node == 7'd0) ? 7'd1 : cfg_node;
  endfunction

  function automatic logic [31:0] byte_mask(logic [2:0] nbytes);
    return (nbytes >= 3'd4) ? 32'hFFFF_FFFF : ((32'h1 << (8 * nbytes)) - 32'h1);
  endfunction

  function automatic bit fifo_push(logic [7:0] s);
    if (rd_count >= QUEUE_DEPTH) return 1'b0;
    rd_fifo[8'((rd_head + rd_count) % QUEUE_DEPTH)] = s;
    rd_count++;
    return 1'b1;
  endfunction

  // Computes the reply to one request and advances the shadow state.
  function automatic reply_t client_reply(sdo_req_t rq);
    reply_t      r;
    logic [2:0]  nbytes;
    logic [7:0]  qs;
    logic [10:0] tx_id;
    logic [10:0] rx_id;
    bit          stop;
    int          i;
    r = '0;
    stop = 1'b0;
    tx_id = COB_TX_BASE + {4'd0, eff_node()};
    rx_id = COB_RX_BASE + {4'd0, eff_node()};
    case (rq.req_type)
      REQ_FRAME: begin
        if (rq.can_id == rx_id && rq.rx_index == cfg_obj && sub_known[rq.sub_index]) begin
          if (rq.rx_cmd == CMD_ABORT) begin
            r.status     = ST_ABORT;
            r.status_sub = rq.sub_index;
            r.read_value = rq.rx_data;
            xfer_kind    = PEND_NONE;
          end else if ((rq.rx_cmd & CMD_CS_MASK) == CMD_UPLOAD) begin
            xfer_kind    = PEND_NONE;
            r.status_sub = rq.sub_index;
            if (rq.rx_cmd[1:0] != 2'b11) begin
              r.status = ST_SEGMENTED;
            end else begin
              // Bits 3..2 count the unused bytes of an expedited upload.
              r.read_size  = 3'd4 - {1'b0, rq.rx_cmd[3:2]};
              r.read_value = rq.rx_data & byte_mask(r.read_size);
              r.status     = ST_READ_DONE;
            end
          end else if (rq.rx_cmd == CMD_DL_ACK) begin
            // The read-back is queued; a full queue drops it.
            xfer_kind    = PEND_NONE;
            r.status_sub = rq.sub_index;
            r.status     = fifo_push(rq.sub_index) ? ST_WRITE_ACK : ST_QUEUE_FULL;
          end
        end
      end
      REQ_READ: begin
        if (!fifo_push(rq.sub_index)) begin
          r.status     = ST_QUEUE_FULL;
          r.status_sub = rq.sub_index;
        end
      end
      REQ_WRITE: begin
        if (cfg_bus && sub_known[rq.sub_index] && xfer_kind == PEND_NONE) begin
          if (!sub_writable[rq.sub_index]) begin
            r.status     = ST_READ_ONLY;
            r.status_sub = rq.sub_index;
          end else begin
            nbytes = (rq.write_size >= 3'd1 && rq.write_size <= 3'd3) ? rq.write_size : 3'd4;
            r.tx_valid  = 1'b1;
            r.tx_cob_id = tx_id;
            case (nbytes)
              3'd1:    r.tx_cmd = CMD_WR1;
              3'd2:    r.tx_cmd = CMD_WR2;
              3'd3:    r.tx_cmd = CMD_WR3;
              default: r.tx_cmd = CMD_WR4;
            endcase
            r.tx_sub   = rq.sub_index;
            r.tx_value = rq.write_value & byte_mask(nbytes);
            xfer_kind  = PEND_WRITE;
            xfer_sub   = rq.sub_index;
          end
        end
      end
      REQ_DEFINE: begin
        sub_known[rq.sub_index]    = 1'b1;
        sub_writable[rq.sub_index] = rq.entry_writable;
      end
      REQ_READ_ALL: begin
        rd_head  = 0;
        rd_count = 0;
        for (i = 0; i < SUB_COUNT; i++) begin
          if (sub_known[8'(i)] && !stop) begin
            if (!fifo_push(i[7:0])) begin
              r.status     = ST_QUEUE_FULL;
              r.status_sub = i[7:0];
              stop         = 1'b1;
            end
          end
        end
      end
      default: ;
    endcase

    // Dispatch of the next queued read when nothing is in flight.
    if (!r.tx_valid && xfer_kind == PEND_NONE && cfg_bus && rd_count > 0) begin
      qs       = rd_fifo[8'(rd_head)];
      rd_head  = (rd_head + 1) % QUEUE_DEPTH;
      rd_count--;
      if (sub_known[qs]) begin
        r.tx_valid  = 1'b1;
        r.tx_cob_id = tx_id;
        r.tx_cmd    = CMD_READ;
        r.tx_sub    = qs;
        r.tx_value  = '0;
        xfer_kind   = PEND_READ;
        xfer_sub    = qs;
      end
    end
    return r;
  endfunction

  function automatic sdo_req_t mk_req(logic [2:0] t, logic [10:0] can, logic [7:0] cmd,
                                      logic [15:0] idx, logic [7:0] sub, logic [31:0] data,
                                      logic [31:0] wval, logic [2:0] wsize, logic wable);
    sdo_req_t rq;
    rq.req_type       = t;
    rq.can_id         = can;
    rq.rx_cmd         = cmd;
    rq.rx_index       = idx;
    rq.sub_index      = sub;
    rq.rx_data        = data;
    rq.write_value    = wval;
    rq.write_size     = wsize;
    rq.entry_writable = wable;
    return rq;
  endfunction

  function automatic reply_t mk_reply(logic txv, logic [10:0] cob, logic [7:0] cmd,
                                      logic [7:0] sub, logic [31:0] val, logic [2:0] st,
                                      logic [7:0] st_sub, logic [31:0] rval,
                                      logic [2:0] rsize);
    reply_t r;
    r.tx_valid   = txv;
    r.tx_cob_id  = cob;
    r.tx_cmd     = cmd;
    r.tx_sub     = sub;
    r.tx_value   = val;
    r.status     = st;
    r.status_sub = st_sub;
    r.read_value = rval;
    r.read_size  = rsize;
    return r;
  endfunction

  // Subindices cluster in a small range so that table hits are common.
  function automatic logic [7:0] pick_sub();
    logic [7:0] s;
    s = 8'($urandom_range(255, 0));
    if ($urandom_range(99, 0) < 80) s[7:4] = 4'd0;
    return s;
  endfunction

  // Random request, mostly well-formed responses and table traffic.
  function automatic sdo_req_t random_request();
    sdo_req_t rq;
    int       pick;
    int       c;
    rq = mk_req(REQ_FRAME, 11'($urandom_range(2047, 0)), 8'($urandom_range(255, 0)),
                16'($urandom_range(65535, 0)), 8'($urandom_range(255, 0)), $urandom,
                $urandom, 3'($urandom_range(7, 0)), 1'($urandom_range(1, 0)));
    pick = $urandom_range(99, 0);
    if (pick < 12) begin
      rq.req_type  = REQ_DEFINE;
      rq.sub_index = pick_sub();
    end else if (pick < 42) begin
      // Response from the target node for the object in use.
      rq.can_id    = COB_RX_BASE + {4'd0, eff_node()};
      rq.rx_index  = cfg_obj;
      rq.sub_index = ($urandom_range(99, 0) < 70) ? xfer_sub : pick_sub();
      c = $urandom_range(99, 0);
      if (c < 25)      rq.rx_cmd = CMD_ABORT;
      else if (c < 60) rq.rx_cmd = CMD_UPLOAD | {3'd0, rq.rx_cmd[4:0]};
      else if (c < 85) rq.rx_cmd = CMD_DL_ACK;
    end else if (pick < 50) begin
      if ($urandom_range(1, 0) == 1) rq.can_id = COB_RX_BASE + {4'd0, eff_node()};
    end else if (pick < 65) begin
      rq.req_type  = REQ_READ;
      rq.sub_index = pick_sub();
    end else if (pick < 90) begin
      rq.req_type  = REQ_WRITE;
      rq.sub_index = pick_sub();
    end else if (pick < 95) begin
      rq.req_type = REQ_READ_ALL;
    end else begin
      rq.req_type = 3'($urandom_range(7, 5));
    end
    return rq;
  endfunction

  // Offers one request and records its reply once accepted.
  task automatic send_request(sdo_req_t rq, logic typed, reply_t given);
    reply_t want;
    while ($urandom_range(99, 0) < req_idle_pct) begin
      req_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    req_if.valid          <= 1'b1;
    req_if.req_type       <= rq.req_type;
    req_if.can_id         <= rq.can_id;
    req_if.rx_cmd         <= rq.rx_cmd;
    req_if.rx_index       <= rq.rx_index;
    req_if.sub_index      <= rq.sub_index;
    req_if.rx_data        <= rq.rx_data;
    req_if.write_value    <= rq.write_value;
    req_if.write_size     <= rq.write_size;
    req_if.entry_writable <= rq.entry_writable;
    @(posedge clk_i);
    while (!req_if.ready) @(posedge clk_i);
    want = client_reply(rq);
    if (typed) want = given;
    replies_due.insert(replies_due.size(), want);
  endtask

  task automatic add_row(logic typed, sdo_req_t rq, reply_t rp);
    row_t row;
    row.typed = typed;
    row.rq    = rq;
    row.rp    = rp;
    rows.insert(rows.size(), row);
  endtask

  task automatic walk_rows();
    int i;
    for (i = 0; i < rows.size(); i++) send_request(rows[i].rq, rows[i].typed, rows[i].rp);
    rows.delete();
  endtask

  task automatic send_mix(int n);
    int k;
    for (k = 0; k < n; k++) send_request(random_request(), 1'b0, '0);
  endtask

  task automatic send_reads(int n);
    sdo_req_t rq;
    int       k;
    for (k = 0; k < n; k++) begin
      rq = random_request();
      rq.req_type  = REQ_READ;
      rq.sub_index = pick_sub();
      send_request(rq, 1'b0, '0);
    end
  endtask

  // Stops offering and waits for every outstanding reply.
  task automatic drain();
    req_if.valid <= 1'b0;
    while (replies_due.size() != 0) @(posedge clk_i);
  endtask

  // Writes all three registers back to back while the block is idle.
  task automatic program_regs(logic [6:0] node, logic bus, logic [15:0] obj);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= CFG_NODE_ID;
    cfg_wdata_i <= {9'd0, node};
    @(posedge clk_i);
    cfg_node = node;
    cfg_idx_i   <= CFG_BUS_OPEN;
    cfg_wdata_i <= {15'd0, bus};
    @(posedge clk_i);
    cfg_bus   = bus;
    xfer_kind = PEND_NONE;
    xfer_sub  = 8'd0;
    rd_head   = 0;
    rd_count  = 0;
    cfg_idx_i   <= CFG_OBJECT_INDEX;
    cfg_wdata_i <= obj;
    @(posedge clk_i);
    cfg_obj = obj;
    cfg_we_i <= 1'b0;
  endtask

  task automatic configure(logic [6:0] node, logic bus, logic [15:0] obj, int snd, int rcv);
    drain();
    repeat (6) @(posedge clk_i);
    program_regs(node, bus, obj);
    req_idle_pct = snd;
    rsp_idle_pct = rcv;
  endtask

  task automatic flag_mismatch(string what, logic [31:0] got, logic [31:0] want);
    if (err_cnt < MAX_PRINTS)
      $display("mismatch on reply %0d, %s got 0x%0h expected 0x%0h",
               reply_cnt, what, got, want);
    err_cnt++;
  endtask

  task automatic check_reply();
    reply_t want;
    if (replies_due.size() == 0) begin
      flag_mismatch("reply with none due", 32'd0, 32'd0);
    end else begin
      want = replies_due.pop_front();
      if (rsp_if.tx_valid !== want.tx_valid)
        flag_mismatch("tx_valid", 32'(rsp_if.tx_valid), 32'(want.tx_valid));
      if (rsp_if.tx_cob_id !== want.tx_cob_id)
        flag_mismatch("tx_cob_id", 32'(rsp_if.tx_cob_id), 32'(want.tx_cob_id));
      if (rsp_if.tx_cmd !== want.tx_cmd)
        flag_mismatch("tx_cmd", 32'(rsp_if.tx_cmd), 32'(want.tx_cmd));
      if (rsp_if.tx_sub !== want.tx_sub)
        flag_mismatch("tx_sub", 32'(rsp_if.tx_sub), 32'(want.tx_sub));
      if (rsp_if.tx_value !== want.tx_value)
        flag_mismatch("tx_value", rsp_if.tx_value, want.tx_value);
      if (rsp_if.status !== want.status)
        flag_mismatch("status code", 32'(rsp_if.status), 32'(want.status));
      if (rsp_if.status_sub !== want.status_sub)
        flag_mismatch("status_sub", 32'(rsp_if.status_sub), 32'(want.status_sub));
      if (rsp_if.read_value !== want.read_value)
        flag_mismatch("read_value", rsp_if.read_value, want.read_value);
      if (rsp_if.read_size !== want.read_size)
        flag_mismatch("read_size", 32'(rsp_if.read_size), 32'(want.read_size));
    end
    reply_cnt++;
  endtask

  // Reply side: checks accepted replies and stalls at random or on a long hold.
  initial begin
    rsp_if.ready <= 1'b0;
    hold_left = 0;
    forever begin
      @(posedge clk_i);
      if (rsp_if.valid && rsp_if.ready) check_reply();
      if (hold_start) begin
        hold_left  = HOLD_CYCLES;
        hold_start = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        rsp_if.ready <= 1'b0;
      end else begin
        rsp_if.ready <= ($urandom_range(99, 0) >= rsp_idle_pct);
      end
    end
  end

  // Request side: reset, directed table, then random phases.
  initial begin
    int i;
    err_cnt      = 0;
    reply_cnt    = 0;
    hold_start   = 1'b0;
    req_idle_pct = 8;
    rsp_idle_pct = 80;
    cfg_node     = NODE_ID_RST;
    cfg_bus      = 1'b0;
    cfg_obj      = OBJECT_INDEX_RST;
    for (i = 0; i < SUB_COUNT; i++) begin
      sub_known[8'(i)]    = 1'b0;
      sub_writable[8'(i)] = 1'b0;
    end
    rd_head   = 0;
    rd_count  = 0;
    xfer_kind = PEND_NONE;
    xfer_sub  = 8'd0;

    rst_ni                <= 1'b0;
    cfg_we_i              <= 1'b0;
    cfg_idx_i             <= '0;
    cfg_wdata_i           <= '0;
    req_if.valid          <= 1'b0;
    req_if.req_type       <= '0;
    req_if.can_id         <= '0;
    req_if.rx_cmd         <= '0;
    req_if.rx_index       <= '0;
    req_if.sub_index      <= '0;
    req_if.rx_data        <= '0;
    req_if.write_value    <= '0;
    req_if.write_size     <= '0;
    req_if.entry_writable <= 1'b0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // Reset settings, bus closed: nothing is sent, the table fills.
    add_row(1, mk_req(REQ_WRITE, 11'h0, 8'h0, 16'h0, 8'h05, 32'h0, 32'hFFFF_FFFF, 3'd4, 1'b1),
            '0);
    add_row(1, mk_req(REQ_READ, 11'h0, 8'h0, 16'h0, 8'hFF, 32'h0, 32'h0, 3'd0, 1'b0), '0);
    add_row(1, mk_req(REQ_FRAME, 11'h581, CMD_ABORT, 16'h23E0, 8'h00, 32'h0, 32'h0, 3'd0,
            1'b0), '0);
    add_row(1, mk_req(REQ_DEFINE, 11'h0, 8'h0, 16'h0, 8'h00, 32'h0, 32'h0, 3'd0, 1'b1), '0);
    add_row(1, mk_req(REQ_DEFINE, 11'h0, 8'h0, 16'h0, 8'hFF, 32'h0, 32'h0, 3'd0, 1'b0), '0);
    add_row(1, mk_req(REQ_FRAME, 11'h581, CMD_ABORT, 16'h23E0, 8'hFF, 32'hFFFF_FFFF, 32'h0,
            3'd0, 1'b0),
            mk_reply(1'b0, 11'h0, 8'h0, 8'h0, 32'h0, ST_ABORT, 8'hFF, 32'hFFFF_FFFF, 3'd0));
    add_row(1, mk_req(REQ_READ_ALL, 11'h0, 8'h0, 16'h0, 8'h00, 32'h0, 32'h0, 3'd0, 1'b0), '0);
    add_row(1, mk_req(REQ_SPARE, 11'h7FF, 8'hFF, 16'hFFFF, 8'hFF, 32'hFFFF_FFFF,
            32'hFFFF_FFFF, 3'd7, 1'b1), '0);
    walk_rows();

    // Highest node, last object index, bus open.
    configure(7'd127, 1'b1, 16'hFFFF, 8, 80);
    add_row(1, mk_req(REQ_WRITE, 11'h0, 8'h0, 16'h0, 8'hFF, 32'h0, 32'h1234_5678, 3'd4, 1'b0),
            mk_reply(1'b0, 11'h0, 8'h0, 8'h0, 32'h0, ST_READ_ONLY, 8'hFF, 32'h0, 3'd0));
    add_row(1, mk_req(REQ_WRITE, 11'h0, 8'h0, 16'h0, 8'h00, 32'h0, 32'hFFFF_FFFF, 3'd1, 1'b0),
            mk_reply(1'b1, 11'h67F, CMD_WR1, 8'h00, 32'hFF, ST_NONE, 8'h0, 32'h0, 3'd0));
    // Refused while the write is pending.
    add_row(0, mk_req(REQ_WRITE, 11'h0, 8'h0, 16'h0, 8'h00, 32'h0, 32'hABCD, 3'd2, 1'b0), '0);
    // Acknowledge queues a read-back, which is sent at once.
    add_row(0, mk_req(REQ_FRAME, 11'h5FF, CMD_DL_ACK, 16'hFFFF, 8'h00, 32'h0, 32'h0, 3'd0,
            1'b0), '0);
    add_row(0, mk_req(REQ_FRAME, 11'h5FF, 8'h4F, 16'hFFFF, 8'h00, 32'hFFFF_FFFF, 32'h0, 3'd0,
            1'b0), '0);
    add_row(0, mk_req(REQ_FRAME, 11'h5FF, 8'h43, 16'hFFFF, 8'h00, 32'h8765_4321, 32'h0, 3'd0,
            1'b0), '0);
    add_row(0, mk_req(REQ_FRAME, 11'h5FF, 8'h42, 16'hFFFF, 8'h00, 32'h5555_AAAA, 32'h0, 3'd0,
            1'b0), '0);
    // Command bytes outside the handled set, then foreign id and index.
    add_row(0, mk_req(REQ_FRAME, 11'h5FF, 8'h61, 16'hFFFF, 8'h00, 32'h0, 32'h0, 3'd0, 1'b0),
            '0);
    add_row(0, mk_req(REQ_FRAME, 11'h580, CMD_ABORT, 16'hFFFF, 8'h00, 32'h1, 32'h0, 3'd0,
            1'b0), '0);
    add_row(0, mk_req(REQ_FRAME, 11'h5FF, CMD_ABORT, 16'h0000, 8'h00, 32'h1, 32'h0, 3'd0,
            1'b0), '0);
    // A queued read of an unknown subindex is popped without a frame.
    add_row(0, mk_req(REQ_READ, 11'h0, 8'h0, 16'h0, 8'h7E, 32'h0, 32'h0, 3'd0, 1'b0), '0);
    add_row(0, mk_req(REQ_WRITE, 11'h0, 8'h0, 16'h0, 8'h00, 32'h0, 32'h00C0_FFEE, 3'd3, 1'b0),
            '0);
    add_row(0, mk_req(REQ_FRAME, 11'h5FF, CMD_DL_ACK, 16'hFFFF, 8'h00, 32'h0, 32'h0, 3'd0,
            1'b0), '0);
    add_row(0, mk_req(REQ_FRAME, 11'h5FF, CMD_ABORT, 16'hFFFF, 8'h00, 32'h0800_0020, 32'h0,
            3'd0, 1'b0), '0);
    // Size zero means four bytes.
    add_row(0, mk_req(REQ_WRITE, 11'h0, 8'h0, 16'h0, 8'h00, 32'h0, 32'hDEAD_BEEF, 3'd0, 1'b0),
            '0);
    add_row(0, mk_req(REQ_READ_ALL, 11'h0, 8'h0, 16'h0, 8'h00, 32'h0, 32'h0, 3'd0, 1'b0), '0);
    add_row(0, mk_req(REQ_FRAME, 11'h5FF, CMD_DL_ACK, 16'hFFFF, 8'h00, 32'h0, 32'h0, 3'd0,
            1'b0), '0);
    walk_rows();

    // Random traffic with a long stall on the reply side.
    configure(7'($urandom_range(127, 1)), 1'b1, 16'($urandom_range(65535, 0)), 8, 80);
    send_mix(40);
    hold_start = 1'b1;
    send_mix(260);

    // Node zero, bus closed: reads pile up until the queue overflows.
    configure(7'd0, 1'b0, 16'h0000, 8, 80);
    send_reads(262);
    send_mix(30);

    // A read in flight blocks dispatch, the queue fills and the ack overflows it.
    configure(7'd127, 1'b1, 16'hFFFF, 80, 8);
    send_request(mk_req(REQ_DEFINE, 11'h0, 8'h0, 16'h0, 8'd3, 32'h0, 32'h0, 3'd0, 1'b1),
                 1'b0, '0);
    send_request(mk_req(REQ_READ, 11'h0, 8'h0, 16'h0, 8'd3, 32'h0, 32'h0, 3'd0, 1'b0),
                 1'b0, '0);
    send_reads(258);
    send_request(mk_req(REQ_FRAME, COB_RX_BASE + {4'd0, eff_node()}, CMD_DL_ACK, cfg_obj,
                        8'd3, $urandom, $urandom, 3'd0, 1'b0), 1'b0, '0);
    send_mix(30);

    // Sender pauses until every reply is back, then goes on.
    configure(7'($urandom_range(127, 1)), 1'b1, 16'($urandom_range(65535, 0)), 80, 8);
    send_mix(100);
    drain();
    send_mix(150);

    // No idling on either side.
    configure(7'd1, 1'b1, 16'h0000, 0, 0);
    send_mix(180);
    configure(7'($urandom_range(127, 1)), 1'b0, 16'($urandom_range(65535, 0)), 0, 0);
    send_mix(100);
    configure(7'($urandom_range(127, 1)), 1'b1, 16'($urandom_range(65535, 0)), 0, 0);
    send_mix(150);

    drain();
    repeat (10) @(posedge clk_i);
    if (err_cnt == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

endmodule
